// File: sv/blum_pkg.sv
// Shared constants, controller states and command/status types of the Blum integer test.
`default_nettype none

package blum_pkg;

    localparam int VALUE_BITS_DEF = 16;
    localparam int LIMIT_BITS     = 17;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 17'h10000;
    localparam int MIN_CANDIDATE  = 4;
    localparam int FIRST_DIVISOR  = 2;
    localparam logic [1:0] MOD4_THREE = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_EVAL,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic inc_d;
        logic load_q;
        logic res_we;
        logic res_val;
    } cmd_t;

    typedef struct packed {
        logic in_range;
        logic div_last;
        logic d_le_quo;
        logic rem_zero;
        logic p_mod3;
        logic q_mod3;
    } status_t;

endpackage

`default_nettype wire

// File: sv/blum_datapath.sv
// Datapath: limit register, trial divisor, shared restoring divider and result register.
`default_nettype none

module blum_datapath #(
    parameter int VALUE_BITS = blum_pkg::VALUE_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [blum_pkg::LIMIT_BITS-1:0] cfg_wdata,
    input  wire logic [VALUE_BITS-1:0]           candidate,
    input  wire blum_pkg::cmd_t                  cmd,
    output blum_pkg::status_t                    status,
    output logic                                 is_blum
);
    import blum_pkg::*;

    localparam int W    = VALUE_BITS;
    localparam int CW   = $clog2(W);
    localparam int CMPW = (W > LIMIT_BITS) ? W : LIMIT_BITS;

    logic [LIMIT_BITS-1:0] limit_reg;
    logic [W-1:0]          n_reg;
    logic [W-1:0]          d_reg;
    logic [W-1:0]          rem_reg;
    logic [W-1:0]          quo_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  is_blum_reg;

    logic [W:0] shifted;
    logic [W:0] diff;
    logic       fits;

    // one quotient bit per cycle in div_step; quo_reg shifts dividend out, quotient in
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = shifted - {1'b0, d_reg};
    assign fits    = shifted >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg <= candidate;
            d_reg <= W'(FIRST_DIVISOR);
        end
        else
        begin
            if (cmd.load_q)
                n_reg <= quo_reg;
            if (cmd.inc_d)
                d_reg <= d_reg + W'(1);
        end

        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= n_reg;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= fits ? diff[W-1:0] : shifted[W-1:0];
            quo_reg <= {quo_reg[W-2:0], fits};
            cnt_reg <= cnt_reg + CW'(1);
        end

        if (cmd.res_we)
            is_blum_reg <= cmd.res_val;
    end

    always_comb
    begin
        status.in_range = (CMPW'(n_reg) < CMPW'(limit_reg)) && (n_reg >= W'(MIN_CANDIDATE));
        status.div_last = cnt_reg == CW'(W - 1);
        // d*d <= n holds exactly when d <= floor(n/d)
        status.d_le_quo = d_reg <= quo_reg;
        status.rem_zero = rem_reg == '0;
        status.p_mod3   = d_reg[1:0] == MOD4_THREE;
        status.q_mod3   = quo_reg[1:0] == MOD4_THREE;
    end

    assign is_blum = is_blum_reg;

endmodule

`default_nettype wire

// File: sv/blum_ctrl.sv
// Controller: sequences trial division for the smallest factor, then the cofactor prime test.
`default_nettype none

module blum_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire blum_pkg::status_t status,
    output blum_pkg::cmd_t         cmd
);
    import blum_pkg::*;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;   // 0: search factor of n, 1: prime test of cofactor
    logic   res_reg, res_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 1'b0;
            res_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        s_tready       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    phase_next = 1'b0;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (!phase_reg && !status.in_range)
                begin
                    res_next   = 1'b0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!status.d_le_quo)
                begin
                    // no divisor up to the square root: n is prime, q is prime
                    res_next   = phase_reg;
                    state_next = ST_FINISH;
                end
                else if (status.rem_zero)
                begin
                    if (!phase_reg && status.p_mod3 && status.q_mod3)
                    begin
                        // q has no factor below p, so the search continues from d = p
                        cmd.load_q = 1'b1;
                        phase_next = 1'b1;
                        state_next = ST_START;
                    end
                    else
                    begin
                        res_next   = 1'b0;
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    cmd.inc_d  = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.res_we     = 1'b1;
                    cmd.res_val    = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// File: sv/blum_integer_test_top.sv
// Top level of the Blum integer test: stream ports, controller and datapath.
// After an input transaction, each trial of the factor search and cofactor prime test passes
//   START, DIV and EVAL; a candidate out of range goes from START straight to FINISH.
// Each trial runs the shared restoring divider, one quotient bit per cycle.
// One item at a time: a new item is accepted only once the FSM is back in IDLE.
// A finished result waits in the output register while the next item is accepted.
// Reset (rst_n, async, active low): limit returns to 65536, no result pending, FSM idle.
`default_nettype none

module blum_integer_test_top #(
    parameter int VALUE_BITS = blum_pkg::VALUE_BITS_DEF,
    parameter int TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [TDATA_BITS-1:0]           s_tdata,   // [VALUE_BITS-1:0] candidate
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [7:0]                           m_tdata,   // [0] is_blum
    input  wire logic                            cfg_we,
    input  wire logic [blum_pkg::LIMIT_BITS-1:0] cfg_wdata  // limit_n
);
    import blum_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    is_blum;

    blum_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    blum_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .candidate (s_tdata[VALUE_BITS-1:0]),
        .cmd       (cmd),
        .status    (status),
        .is_blum   (is_blum)
    );

    assign m_tdata = {7'b0, is_blum};

endmodule

`default_nettype wire

// File: sv/blum_checker.sv
// Port-level checker of the Blum integer test and its bind to the top level.
`default_nettype none

module blum_checker #(
    parameter int TDATA_BITS = 16
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [TDATA_BITS-1:0] s_tdata,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [7:0]            m_tdata
);

    // held result transaction keeps valid and data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    a_out_valid_only: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared with no item in work");

    // one item at a time: input closes right after a transaction
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready while item in work");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:1] == 7'b0)
        else $error("result padding bits set");

    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !$isunknown(s_tdata))
        else $error("unknown candidate in input transaction");

endmodule

bind blum_integer_test_top blum_checker #(
    .TDATA_BITS (TDATA_BITS)
) u_blum_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
